@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the palette downscaler RTL.
// Each macro expects clk and the active-low reset rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/pbd_pkg.sv @@
// Shared types and constants for the palette box downscaler.
// No dependencies; used by pbd_lookup, pbd_sum, pbd_fold and the top level.
`default_nettype none

package pbd_pkg;

  // Field widths fixed by the interface
  localparam int IDX_W   = 8;
  localparam int WORD_W  = 32;
  localparam int PIXEL_W = 16;
  localparam int LANES   = 4;

  // Default palette depth
  localparam int PALETTE_DEPTH_DEF = 256;

  // Every colour bit of a spread RGB565 word
  localparam logic [WORD_W-1:0] SPREAD_MASK = 32'h07e0_f81f;

  // Item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Scale mode register codes
  typedef enum logic [1:0] {
    SCALE_SINGLE = 2'd0,
    SCALE_HPAIR  = 2'd1,
    SCALE_VPAIR  = 2'd2,
    SCALE_QUAD   = 2'd3
  } scale_mode_t;

  // Control of the lookup stage: valid plus which lanes count
  typedef struct packed {
    logic             valid;
    logic [LANES-1:0] keep;
  } lk_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/pbd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pbd_lookup.sv @@
// Stage 1: palette storage and lookup of the four colour indices.
// Depends on pbd_pkg and pbd_ram (one copy of the palette per read lane).
`default_nettype none

module pbd_lookup #(
  parameter int PALETTE_DEPTH = pbd_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        in_valid,
  input  wire logic                                        in_kind,
  input  wire logic [pbd_pkg::IDX_W-1:0]                   in_top_left,
  input  wire logic [pbd_pkg::IDX_W-1:0]                   in_top_right,
  input  wire logic [pbd_pkg::IDX_W-1:0]                   in_bottom_left,
  input  wire logic [pbd_pkg::IDX_W-1:0]                   in_bottom_right,
  input  wire logic [pbd_pkg::IDX_W-1:0]                   in_entry_index,
  input  wire logic [pbd_pkg::WORD_W-1:0]                  in_entry_value,
  input  wire pbd_pkg::scale_mode_t                        scale_mode,
  input  wire logic                                        en_next,
  output logic                                             en,
  output pbd_pkg::lk_ctl_t                                 s1_ctl,
  output logic [pbd_pkg::LANES-1:0][pbd_pkg::WORD_W-1:0]   s1_word
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam logic [pbd_pkg::IDX_W:0] DEPTH_L = (pbd_pkg::IDX_W + 1)'(PALETTE_DEPTH);

  logic [pbd_pkg::LANES-1:0][pbd_pkg::IDX_W-1:0] idx_sel;
  logic [pbd_pkg::LANES-1:0]                     use_lane;
  logic [pbd_pkg::LANES-1:0]                     in_range;
  logic                                          accept;
  logic                                          wr_en;
  pbd_pkg::lk_ctl_t                              s1_ctl_r;
  pbd_pkg::lk_ctl_t                              s1_ctl_nxt;

  // Advance when empty or when the next stage takes our beat
  assign en     = !s1_ctl_r.valid || en_next;
  assign accept = in_valid && en;

  // Pick the index for each lane; lane 1 is the bottom pixel in vertical-pair mode
  always_comb begin
    idx_sel[0] = in_top_left;
    idx_sel[1] = (scale_mode == pbd_pkg::SCALE_VPAIR) ? in_bottom_left : in_top_right;
    idx_sel[2] = in_bottom_left;
    idx_sel[3] = in_bottom_right;
    use_lane[0] = 1'b1;
    use_lane[1] = (scale_mode != pbd_pkg::SCALE_SINGLE);
    use_lane[2] = (scale_mode == pbd_pkg::SCALE_QUAD);
    use_lane[3] = (scale_mode == pbd_pkg::SCALE_QUAD);
    for (int k = 0; k < pbd_pkg::LANES; k++) begin
      in_range[k] = ({1'b0, idx_sel[k]} < DEPTH_L);
    end
  end

  // Write only slots that exist
  assign wr_en = accept && (in_kind == pbd_pkg::KIND_WRITE)
                 && ({1'b0, in_entry_index} < DEPTH_L);

  // One palette copy per lane, all written together
  for (genvar g = 0; g < pbd_pkg::LANES; g++) begin : g_lane
    pbd_ram #(
      .WIDTH (pbd_pkg::WORD_W),
      .DEPTH (PALETTE_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (wr_en),
      .waddr (in_entry_index[AW-1:0]),
      .wdata (in_entry_value),
      .re    (accept),
      .raddr (idx_sel[g][AW-1:0]),
      .rdata (s1_word[g])
    );
  end

  // Only pixel beats carry on down the pipe
  always_comb begin
    s1_ctl_nxt.valid = in_valid && (in_kind == pbd_pkg::KIND_PIXEL);
    s1_ctl_nxt.keep  = use_lane & in_range;
  end

  // Valid is reset; the lane mask just follows it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r.valid <= 1'b0;
    end else if (en) begin
      s1_ctl_r.valid <= s1_ctl_nxt.valid;
    end
    if (en) begin
      s1_ctl_r.keep <= s1_ctl_nxt.keep;
    end
  end

  assign s1_ctl = s1_ctl_r;

endmodule

`default_nettype wire

@@ rtl/core/pbd_sum.sv @@
// Stages 2 and 3: pairwise sums of the looked-up words, then the total.
// Depends on pbd_pkg.
`default_nettype none

module pbd_sum (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire pbd_pkg::lk_ctl_t                           s1_ctl,
  input  wire logic [pbd_pkg::LANES-1:0][pbd_pkg::WORD_W-1:0] s1_word,
  input  wire logic                                       en_next,
  output logic                                            en,
  output logic                                            s3_valid,
  output logic [pbd_pkg::WORD_W-1:0]                      s3_total
);

  logic [pbd_pkg::LANES-1:0][pbd_pkg::WORD_W-1:0] word_q;
  logic                                           s2_valid_r;
  logic [pbd_pkg::WORD_W-1:0]                     sum_lo_r;
  logic [pbd_pkg::WORD_W-1:0]                     sum_hi_r;
  logic [pbd_pkg::WORD_W-1:0]                     sum_lo_nxt;
  logic [pbd_pkg::WORD_W-1:0]                     sum_hi_nxt;
  logic                                           s3_valid_r;
  logic [pbd_pkg::WORD_W-1:0]                     total_r;
  logic [pbd_pkg::WORD_W-1:0]                     total_nxt;
  logic                                           en3;

  // Stage enables: advance when empty or drained downstream
  assign en3 = !s3_valid_r || en_next;
  assign en  = !s2_valid_r || en3;

  // Drop lanes the mode does not use or whose index is out of range
  always_comb begin
    for (int k = 0; k < pbd_pkg::LANES; k++) begin
      word_q[k] = s1_word[k] & {pbd_pkg::WORD_W{s1_ctl.keep[k]}};
    end
    sum_lo_nxt = word_q[0] + word_q[1];
    sum_hi_nxt = word_q[2] + word_q[3];
    total_nxt  = sum_lo_r + sum_hi_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (en) begin
        s2_valid_r <= s1_ctl.valid;
      end
      if (en3) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  // Payload, modulo 2^32
  always_ff @(posedge clk) begin
    if (en) begin
      sum_lo_r <= sum_lo_nxt;
      sum_hi_r <= sum_hi_nxt;
    end
    if (en3) begin
      total_r <= total_nxt;
    end
  end

  assign s3_valid = s3_valid_r;
  assign s3_total = total_r;

endmodule

`default_nettype wire

@@ rtl/core/pbd_fold.sv @@
// Stage 4: mask, shift and fold of the summed word into RGB565; output register.
// Depends on pbd_pkg.
`default_nettype none

module pbd_fold (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          s3_valid,
  input  wire logic [pbd_pkg::WORD_W-1:0]    s3_total,
  input  wire pbd_pkg::scale_mode_t          scale_mode,
  input  wire logic                          out_stall,
  output logic                               en,
  output logic                               out_valid,
  output logic [pbd_pkg::PIXEL_W-1:0]        out_pixel
);

  logic                         out_valid_r;
  logic [pbd_pkg::PIXEL_W-1:0]  pixel_r;
  logic [pbd_pkg::PIXEL_W-1:0]  pixel_nxt;
  logic [pbd_pkg::WORD_W-1:0]   masked;

  // Take a new beat when the output is empty or being taken
  assign en = !out_valid_r || !out_stall;

  // Divide by the lane count and fold green down onto red and blue
  always_comb begin
    masked    = '0;
    pixel_nxt = '0;
    case (scale_mode)
      pbd_pkg::SCALE_SINGLE: begin
        pixel_nxt = pbd_pkg::PIXEL_W'(s3_total | (s3_total >> 16));
      end
      pbd_pkg::SCALE_HPAIR: begin
        masked    = s3_total & (pbd_pkg::SPREAD_MASK << 1);
        pixel_nxt = pbd_pkg::PIXEL_W'((masked >> 1) | (masked >> 17));
      end
      pbd_pkg::SCALE_VPAIR: begin
        masked    = s3_total & (pbd_pkg::SPREAD_MASK << 1);
        pixel_nxt = pbd_pkg::PIXEL_W'((masked >> 1) | (masked >> 17));
      end
      pbd_pkg::SCALE_QUAD: begin
        masked    = s3_total & (pbd_pkg::SPREAD_MASK << 2);
        pixel_nxt = pbd_pkg::PIXEL_W'((masked >> 2) | (masked >> 18));
      end
      default: begin
        pixel_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pixel_r <= pixel_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = pixel_r;

endmodule

`default_nettype wire

@@ rtl/core/palette_box_downscale_rgb565.sv @@
// Palette box downscaler, top level: palette lookup of a 2x2 index block,
// averaging in spread-RGB565 form, one RGB565 pixel out.
//
// Channels: in_* carries one beat per item, either a pixel group (in_kind 0)
// or a palette write (in_kind 1); out_* carries one RGB565 pixel per pixel
// group. A beat moves at a rising edge with valid high and stall low.
// cfg_* writes scale_mode; cfg_ready is always high. Write it only while no
// pixel is in flight.
// Pipeline: the palette read happens at the accepting edge, then come the pair
// sums, the total, and the fold into the output register, where out_valid
// rises. Throughput is one item per cycle while in_stall is low. A palette
// write is visible to pixel beats accepted from the next cycle on and
// produces no result.
// Reset clears every stage valid and sets scale_mode to single pixel; palette
// contents stay undefined until written, so no clearing pass is needed.
// While out_stall holds, results stay in the output register; empty stages
// behind it still fill, and in_stall rises only once every stage is full.
`default_nettype none

module palette_box_downscale_rgb565 #(
  parameter int PALETTE_DEPTH = pbd_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_kind,
  input  wire logic [pbd_pkg::IDX_W-1:0]       in_top_left,
  input  wire logic [pbd_pkg::IDX_W-1:0]       in_top_right,
  input  wire logic [pbd_pkg::IDX_W-1:0]       in_bottom_left,
  input  wire logic [pbd_pkg::IDX_W-1:0]       in_bottom_right,
  input  wire logic [pbd_pkg::IDX_W-1:0]       in_entry_index,
  input  wire logic [pbd_pkg::WORD_W-1:0]      in_entry_value,
  // Result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [pbd_pkg::PIXEL_W-1:0]          out_pixel,
  // Configuration write
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [1:0]                      cfg_scale_mode
);

  pbd_pkg::scale_mode_t                            scale_mode_r;
  pbd_pkg::lk_ctl_t                                s1_ctl;
  logic [pbd_pkg::LANES-1:0][pbd_pkg::WORD_W-1:0]  s1_word;
  logic                                            en1;
  logic                                            en2;
  logic                                            en4;
  logic                                            s3_valid;
  logic [pbd_pkg::WORD_W-1:0]                      s3_total;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_mode_r <= pbd_pkg::SCALE_SINGLE;
    end else if (cfg_valid && cfg_ready) begin
      scale_mode_r <= pbd_pkg::scale_mode_t'(cfg_scale_mode);
    end
  end

  // Stage 1: palette lookup
  pbd_lookup #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_lookup (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_kind         (in_kind),
    .in_top_left     (in_top_left),
    .in_top_right    (in_top_right),
    .in_bottom_left  (in_bottom_left),
    .in_bottom_right (in_bottom_right),
    .in_entry_index  (in_entry_index),
    .in_entry_value  (in_entry_value),
    .scale_mode      (scale_mode_r),
    .en_next         (en2),
    .en              (en1),
    .s1_ctl          (s1_ctl),
    .s1_word         (s1_word)
  );

  assign in_stall = !en1;

  // Stages 2 and 3: adder tree
  pbd_sum u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_ctl   (s1_ctl),
    .s1_word  (s1_word),
    .en_next  (en4),
    .en       (en2),
    .s3_valid (s3_valid),
    .s3_total (s3_total)
  );

  // Stage 4: fold and output register
  pbd_fold u_fold (
    .clk        (clk),
    .rst_n      (rst_n),
    .s3_valid   (s3_valid),
    .s3_total   (s3_total),
    .scale_mode (scale_mode_r),
    .out_stall  (out_stall),
    .en         (en4),
    .out_valid  (out_valid),
    .out_pixel  (out_pixel)
  );

  // Checks on the pipeline control
`include "assert_macros.svh"

  `ASSERT_IMPL(a_stall_only_when_full, in_stall, out_valid && out_stall,
               "input stalled while the output is not blocked")
  `ASSERT_NEXT(a_pixel_enters_stage1,
               in_valid && !in_stall && (in_kind == pbd_pkg::KIND_PIXEL), s1_ctl.valid,
               "accepted pixel beat did not reach the lookup stage")
  `ASSERT_IMPL(a_result_has_source, out_valid && !$past(out_valid), $past(s3_valid),
               "result appeared without a summed beat behind it")

endmodule

`default_nettype wire
